>>> hw/rtl/wdrt_pkg.sv
// wdrt_pkg: beat types, command/status structs and fixed constants for the
// windowed damage-rate tracker. No dependencies.
package wdrt_pkg;

    // APB address: one 32-bit register at byte 0; bit 2 selects the index.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_WINDOW = 1'd0;

    localparam logic [15:0] WINDOW_RESET  = 16'd1000;
    localparam logic [7:0]  REPORT_LENGTH = 8'd15;
    localparam logic        REQ_HEALTH    = 1'b0;

    localparam logic [31:0] SUM_MAX = 32'd1048575;
    localparam logic [15:0] CNT_MAX = 16'd31;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic [31:0] msg_time_ms;
        logic [7:0]  msg_length;
        logic [15:0] health_value;
    } in_beat_t;

    typedef struct packed {
        logic [19:0] window_sum;
        logic [4:0]  events_held;
        logic        event_recorded;
        logic [4:0]  expired_count;
    } out_beat_t;

    // one stored loss event
    typedef struct packed {
        logic [15:0] amount;
        logic [31:0] stamp;
    } event_t;

    typedef struct packed {
        logic load_in;
        logic pop_expire;
        logic push;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic can_expire;
    } dp_sts_t;

endpackage

>>> hw/rtl/wdrt_dp.sv
// wdrt_dp: event FIFO memory, pointers, running sum and result register.
// Depends on wdrt_pkg; driven by wdrt_ctrl through dp_cmd_t.
module wdrt_dp
    import wdrt_pkg::*;
#(
    parameter int EVENT_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  in_data,
    input  logic [15:0] window_ms,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output out_beat_t out_data
);

    localparam int PTR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CNT_W = $clog2(EVENT_DEPTH + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(EVENT_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(EVENT_DEPTH);

    event_t mem [EVENT_DEPTH];
    event_t rd_data_reg;

    in_beat_t         req_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [15:0]      last_health_reg, last_health_next;
    logic [CNT_W-1:0] expired_reg, expired_next;
    logic             recorded_reg, recorded_next;
    out_beat_t        out_reg;

    logic [PTR_W-1:0] head_inc, tail_inc, rd_addr;
    logic [31:0]      age;
    logic             report_ok, drop_ok, full, pop, wr_en;
    logic [15:0]      drop;
    logic [31:0]      sum_ext;
    logic [15:0]      held_ext, exp_ext;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;

    // wrap-around age of the oldest event
    assign age = req_reg.now_ms - rd_data_reg.stamp;
    assign sts.can_expire = (count_reg != '0) && (age > {16'd0, window_ms});

    assign report_ok = (req_reg.req_type == REQ_HEALTH) && (req_reg.msg_length == REPORT_LENGTH);
    assign drop_ok   = report_ok && (req_reg.health_value < last_health_reg);
    assign drop      = last_health_reg - req_reg.health_value;
    assign full      = (count_reg == CNT_FULL);
    assign wr_en     = cmd.push && drop_ok;
    // age expiry, or eviction of the oldest when pushing into a full FIFO
    assign pop       = cmd.pop_expire || (wr_en && full);
    // read ahead so the new head is ready in the next cycle
    assign rd_addr   = pop ? head_inc : head_reg;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        last_health_next = last_health_reg;
        expired_next     = expired_reg;
        recorded_next    = recorded_reg;
        if (cmd.load_in)
        begin
            expired_next  = '0;
            recorded_next = 1'b0;
        end
        if (cmd.pop_expire)
        begin
            head_next    = head_inc;
            count_next   = count_reg - 1'b1;
            sum_next     = sum_reg - SUM_W'(rd_data_reg.amount);
            expired_next = expired_reg + 1'b1;
        end
        if (wr_en)
        begin
            tail_next     = tail_inc;
            recorded_next = 1'b1;
            if (full)
            begin
                head_next = head_inc;
                sum_next  = sum_reg - SUM_W'(rd_data_reg.amount) + SUM_W'(drop);
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(drop);
            end
        end
        if (cmd.push && report_ok)
        begin
            last_health_next = req_reg.health_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            last_health_reg <= '0;
            expired_reg     <= '0;
            recorded_reg    <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            last_health_reg <= last_health_next;
            expired_reg     <= expired_next;
            recorded_reg    <= recorded_next;
        end
    end

    // event store: one write port at the tail, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= '{amount: drop, stamp: req_reg.msg_time_ms};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign sum_ext  = 32'(sum_reg);
    assign held_ext = 16'(count_reg);
    assign exp_ext  = 16'(expired_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= in_data;
        end
        if (cmd.load_out)
        begin
            out_reg.window_sum     <= (sum_ext > SUM_MAX) ? SUM_MAX[19:0] : sum_ext[19:0];
            out_reg.events_held    <= (held_ext > CNT_MAX) ? CNT_MAX[4:0] : held_ext[4:0];
            out_reg.event_recorded <= recorded_reg;
            out_reg.expired_count  <= (exp_ext > CNT_MAX) ? CNT_MAX[4:0] : exp_ext[4:0];
        end
    end

    assign out_data = out_reg;

endmodule

>>> hw/rtl/wdrt_ctrl.sv
// wdrt_ctrl: sequencer for accept, expiry loop, push and result hand-off.
// Depends on wdrt_pkg; commands wdrt_dp.
module wdrt_ctrl
    import wdrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_PUSH  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.can_expire)
                begin
                    cmd.pop_expire = 1'b1;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/windowed_damage_rate_tracker_unit.sv
// Windowed damage-rate tracker: health lost by events inside a sliding window.
// Per beat: taken in idle; the age loop expires E events (E <= EVENT_DEPTH);
// push; result register load, stalled while out_valid waits on out_ready;
// next beat only back in idle. The age loop pops one event per cycle through
// the single read port of the event memory. rst_n clears pointers, sum, last
// health and handshake state at once; window_ms returns to 1000.
// Depends on wdrt_pkg, wdrt_ctrl, wdrt_dp.
module windowed_damage_rate_tracker_unit
    import wdrt_pkg::*;
#(
    parameter int EVENT_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  in_beat_t           in_data,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_data,
    // APB register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] window_reg;
    logic        sel_window;
    dp_cmd_t     cmd;
    dp_sts_t     sts;

    // Register map: index = paddr[2]; only window_ms at index 0.
    // A write lands in the access phase; pready is tied high (no wait states).
    assign pready     = 1'b1;
    assign sel_window = (paddr[PADDR_W-1:2] == REG_WINDOW);
    assign prdata     = sel_window ? {16'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_window)
        begin
            window_reg <= pwdata[15:0];
        end
    end

    // Sequencer: idle -> age check loop -> push -> result register.
    wdrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: circular event FIFO in memory, running sum, output register.
    wdrt_dp #(
        .EVENT_DEPTH (EVENT_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .window_ms (window_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

    // An empty FIFO must carry no loss.
    a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.events_held == 5'd0) |-> (out_data.window_sum == 20'd0))
        else $error("window_sum nonzero with no events held");

    // A recorded event is always held afterwards.
    a_recorded_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_recorded |-> (out_data.events_held != 5'd0))
        else $error("event recorded but FIFO empty");

    // The sequencer is out of idle in the cycle after it takes a beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // Expiry never removes more than the FIFO can hold.
    a_expired_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (16'(out_data.expired_count) <= 16'(EVENT_DEPTH)
                       || out_data.expired_count == CNT_MAX[4:0]))
        else $error("expired_count above FIFO depth");

endmodule
